// ===== rtl/core/skf_pkg.sv =====
// Shared widths, constants and control types for the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CNT_W     = $clog2(FRAC_W);
  localparam int EXT_W     = DATA_W + 1;
  localparam int PROD_W    = EXT_W + FRAC_W + 1;

  localparam logic [FRAC_W:0]    ONE_FIX  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(FRAC_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = DATA_W'(655);
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = DATA_W'(65536);

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_x;
    logic mul_p;
    logic commit;
  } skf_cmd_t;

endpackage

// ===== rtl/core/skf_dp.sv =====
// Datapath: prediction, restoring gain divider, shared multiplier, state update.
module skf_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  skf_pkg::skf_cmd_t         cmd,
  input  logic [skf_pkg::DATA_W-1:0] sample,
  input  logic [skf_pkg::DATA_W-1:0] q_noise,
  input  logic [skf_pkg::DATA_W-1:0] r_noise,
  output logic [skf_pkg::DATA_W-1:0] filtered,
  output logic [skf_pkg::DATA_W-1:0] error_variance
);
  import skf_pkg::*;

  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] p_r, p_nxt;
  logic [DATA_W-1:0] pp_r;
  logic [EXT_W-1:0]  d_r;
  logic [EXT_W-1:0]  mag_r;
  logic              neg_r;
  logic [EXT_W-1:0]  den_r;
  logic              den0_r;
  logic              sat_r;
  logic [EXT_W-1:0]  rem_r;
  logic [FRAC_W-1:0] quo_r;
  logic [PROD_W-1:0] prod_r;
  logic [DATA_W-1:0] xn_r;

  logic [EXT_W-1:0]  pp_sum;
  logic [EXT_W-1:0]  d_val;
  logic [EXT_W:0]    trial;
  logic [EXT_W:0]    trial_sub;
  logic [FRAC_W-1:0] gain;
  logic [EXT_W-1:0]  mul_a;
  logic [FRAC_W:0]   mul_b;
  logic [EXT_W-1:0]  step;
  logic [EXT_W:0]    x_ext;
  logic [EXT_W:0]    x_new;

  assign pp_sum    = {1'b0, p_r} + {1'b0, q_noise};
  assign d_val     = {sample[DATA_W-1], sample} - {x_r[DATA_W-1], x_r};
  assign trial     = {rem_r, 1'b0};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    if (den0_r) begin
      gain = '0;
    end else if (sat_r) begin
      gain = '1;
    end else begin
      gain = quo_r;
    end
  end

  always_comb begin
    if (cmd.mul_x) begin
      mul_a = mag_r;
      mul_b = {1'b0, gain};
    end else begin
      mul_a = {1'b0, pp_r};
      mul_b = ONE_FIX - {1'b0, gain};
    end
  end

  assign step  = prod_r[FRAC_W +: EXT_W];
  assign x_ext = {{2{x_r[DATA_W-1]}}, x_r};
  assign x_new = neg_r ? (x_ext - {1'b0, step}) : (x_ext + {1'b0, step});

  always_comb begin
    x_nxt = x_r;
    p_nxt = p_r;
    if (cmd.commit) begin
      x_nxt = xn_r;
      p_nxt = prod_r[FRAC_W +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      p_r <= '0;
    end else begin
      x_r <= x_nxt;
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pp_r <= pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
      d_r  <= d_val;
    end
    if (cmd.prep) begin
      den_r  <= {1'b0, pp_r} + {1'b0, r_noise};
      den0_r <= (pp_r == '0) && (r_noise == '0);
      sat_r  <= (r_noise == '0);
      neg_r  <= d_r[EXT_W-1];
      mag_r  <= d_r[EXT_W-1] ? (EXT_W'(0) - d_r) : d_r;
      rem_r  <= {1'b0, pp_r};
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial_sub[EXT_W-1:0];
        quo_r <= {quo_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[EXT_W-1:0];
        quo_r <= {quo_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mul_x || cmd.mul_p) begin
      prod_r <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.mul_p) begin
      xn_r <= x_new[DATA_W-1:0];
    end
  end

  assign filtered       = x_r;
  assign error_variance = p_r;

endmodule

// ===== rtl/core/skf_ctrl.sv =====
// Controller: sequences load, divide, multiply and commit; owns the item handshakes.
module skf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output skf_pkg::skf_cmd_t cmd
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MULX,
    ST_MULP,
    ST_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_x    = (state_r == ST_MULX);
    cmd.mul_p    = (state_r == ST_MULP);
    cmd.commit   = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            state_r <= ST_MULX;
          end
        end
        ST_MULX: state_r <= ST_MULP;
        ST_MULP: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.mul_x, cmd.mul_p, cmd.commit}))
    else $error("more than one datapath command");
  a_load_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.prep)
    else $error("load not followed by prep");
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_tvalid && in_tready))
    else $error("commit did not present a result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && state_r == ST_DONE) |=> !out_tvalid || state_r == ST_DONE)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: configuration registers, controller and datapath.
//
//   channel | direction | payload
//   in_     | slave     | tdata[31:0] sample (signed Q16.16)
//   out_    | master    | tdata[31:0] filtered, tdata[63:32] error_variance
//   cfg_    | slave     | index 0 process_noise, 1 measurement_noise; data[31:0]
//
// An item is accepted only in idle; its result is presented after prep, 16 divider
// steps, two passes through the shared multiplier and commit, and the next item is
// accepted only once the controller is back in idle, so a new item is not taken
// before the last one is through. Reset is synchronous, active low, and clears estimate and
// variance. A new item is taken while a result waits; a stalled result holds the
// item at commit until out_tready.
module scalar_kalman_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // [31:0] filtered, [63:32] error_variance
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import skf_pkg::*;

  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] r_r, r_nxt;
  logic [DATA_W-1:0] filtered;
  logic [DATA_W-1:0] error_variance;
  skf_cmd_t          cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     q_nxt = cfg_data;
        REG_MEASUREMENT_NOISE: r_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= PROCESS_NOISE_RST;
      r_r <= MEASUREMENT_NOISE_RST;
    end else begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  skf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sample         (in_tdata),
    .q_noise        (q_r),
    .r_noise        (r_r),
    .filtered       (filtered),
    .error_variance (error_variance)
  );

  assign out_tdata = {error_variance, filtered};

endmodule

// ===== dv/kalman_checker.sv =====
`timescale 1ns / 1ps
// Checker for the scalar Kalman filter: follows register writes, predicts each update, compares results.
module kalman_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] sample
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [63:0]                   out_tdata,  // [31:0] filtered, [63:32] error_variance
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            checked_count
);

  localparam int FRAC = skf_pkg::FRAC_W;
  localparam longint unsigned ONE_Q = longint'(1) << FRAC;

  typedef struct packed {
    logic [31:0] variance;
    logic [31:0] filtered;
  } kf_update_t;

  logic [31:0]        noise_q;
  logic [31:0]        noise_r;
  logic signed [31:0] est_x;
  logic [31:0]        var_p;
  kf_update_t         expected_updates[$];
  int                 fails   = 0;
  int                 checked = 0;

  // advances the filter state by one sample and returns the new estimate and variance
  function automatic kf_update_t kalman_update(input logic [31:0] sample);
    logic [32:0]     p_sum;
    logic [31:0]     p_pred;
    logic [32:0]     denom;
    logic [15:0]     gain;
    longint unsigned num, den, dev_mag, nudge, shrink;
    longint          dev, x_old, x_new;
    kf_update_t      res;
    p_sum  = {1'b0, var_p} + {1'b0, noise_q};
    p_pred = p_sum[32] ? '1 : p_sum[31:0];
    denom  = {1'b0, p_pred} + {1'b0, noise_r};
    num    = p_pred;
    den    = denom;
    if (den == 0) begin
      gain = '0;
    end else if (num >= den) begin
      gain = '1;
    end else begin
      gain = 16'((num << FRAC) / den);
    end
    x_old   = est_x;
    dev     = $signed(sample);
    dev     = dev - x_old;
    dev_mag = (dev < 0) ? -dev : dev;
    nudge   = (dev_mag * gain) >> FRAC;
    x_new   = (dev < 0) ? x_old - longint'(nudge) : x_old + longint'(nudge);
    shrink  = num * (ONE_Q - gain);
    est_x   = 32'(x_new);
    var_p   = 32'(shrink >> FRAC);
    res.filtered = est_x;
    res.variance = var_p;
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    if (fails < 10) begin
      $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    kf_update_t got, want;
    if (!rst_n) begin
      noise_q = skf_pkg::PROCESS_NOISE_RST;
      noise_r = skf_pkg::MEASUREMENT_NOISE_RST;
      est_x   = '0;
      var_p   = '0;
      expected_updates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == skf_pkg::REG_PROCESS_NOISE) begin
          noise_q = cfg_data;
        end else if (cfg_index == skf_pkg::REG_MEASUREMENT_NOISE) begin
          noise_r = cfg_data;
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_updates.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result %h at %0t, nothing pending", out_tdata, $time);
          end
          fails++;
        end else begin
          want = expected_updates.pop_front();
          if (got.filtered !== want.filtered) report("filtered", want.filtered, got.filtered);
          if (got.variance !== want.variance) begin
            report("error_variance", want.variance, got.variance);
          end
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_updates.push_back(kalman_update(in_tdata));
      end
    end
    pending       <= expected_updates.size();
    mismatches    <= fails;
    checked_count <= checked;
  end

endmodule

// ===== dv/scalar_kalman_filter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the scalar Kalman filter: clock, reset, sample and register stimulus, verdict.
module scalar_kalman_filter_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int SEGMENTS    = 10;
  localparam int SEG_ITEMS   = 95;
  localparam int TAIL        = 40;

  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
      skf_pkg::REG_MEASUREMENT_NOISE + 1'b1;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  typedef enum logic [1:0] {PH_DIRECTED, PH_RANDOM, PH_BACKPRESS, PH_STREAM} tb_phase_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [31:0]                   in_tdata;   // [31:0] sample
  logic                          out_tvalid;
  logic                          out_tready;
  logic [63:0]                   out_tdata;  // [31:0] filtered, [63:32] error_variance
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  int        mismatches;
  int        pending;
  int        checked_count;
  tb_phase_t phase       = PH_DIRECTED;
  logic [31:0] level     = '0;
  int        n_samples   = 0;
  int        n_writes    = 0;
  int        n_settings  = 0;
  int        cycle_count = 0;

  logic [31:0] corner_vals [6] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};

  always #10 clk = ~clk;

  scalar_kalman_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kalman_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // mostly short gaps, now and then a long one; none while streaming or in the back-pressure phase
  function automatic int idle_len();
    if (phase == PH_STREAM || phase == PH_BACKPRESS) return 0;
    if ($urandom_range(0, 11) == 0) return $urandom_range(8, 60);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      4:       return $urandom_range(1, 255);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] s);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    n_samples++;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
    write_reg(skf_pkg::REG_PROCESS_NOISE, q);
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r);
    n_settings++;
  endtask

  // sender pauses until every outstanding update has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int  gap;
    bit  held;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (phase == PH_BACKPRESS && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d updates still pending", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] s;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset noise values, sample extremes
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    // variance + Q saturates, largest swings
    wait_idle();
    set_noise('1, '1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    // no measurement noise: gain pinned just below one
    wait_idle();
    set_noise('1, '0);
    send_sample(32'h8000_0000);
    send_sample($urandom());
    // variance collapses to zero, then zero denominator gives zero gain
    wait_idle();
    set_noise('0, '0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    // writes to unused indexes must be ignored
    wait_idle();
    write_reg(REG_SPARE_FIRST, $urandom());
    write_reg(REG_SPARE_LAST, $urandom());
    set_noise('0, '1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      phase = (seg == 3) ? PH_BACKPRESS : (seg == 6) ? PH_STREAM : PH_RANDOM;
      if (seg == 0) begin
        set_noise(skf_pkg::PROCESS_NOISE_RST, skf_pkg::MEASUREMENT_NOISE_RST);
      end else begin
        set_noise(pick_noise(), pick_noise());
      end
      repeat (SEG_ITEMS) begin
        level = level + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        case ($urandom_range(0, 15))
          0:       s = 32'h7FFF_FFFF;
          1:       s = 32'h8000_0000;
          2, 3:    s = $urandom();
          default: s = level + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        send_sample(s);
      end
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d samples over %0d noise settings: extremes, saturated variance,",
             n_samples, n_settings);
    $display("zero noise and zero gain; %0d register writes, %0d updates checked",
             n_writes, checked_count);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
